[design/crrq_pkg.sv]
// Shared types and constants for the coalescing request ring queue.
// Used by crrq_cell and coalescing_request_ring_queue; depends on nothing.
`default_nettype none

package crrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF = 16;
  localparam int ID_PORT_W = 16;
  localparam int VOL_W = 16;
  localparam int LEVEL_W = 8;
  localparam int STATUS_W = 3;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd128;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED = 3'd0,
    ST_QUEUED = 3'd1,
    ST_FULL   = 3'd2,
    ST_SERVED = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVICE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic pop;
    logic enq;
    logic any_hit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/crrq_cell.sv]
// One slot of the queue: holds an id and a volume, compares the id of an
// incoming item and takes its neighbor's slot on a pop. Depends on crrq_pkg.
`default_nettype none

module crrq_cell #(
  parameter int IDW = crrq_pkg::ID_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire crrq_pkg::cell_ctrl_t         ctrl,
  input  wire                               valid,
  input  wire                               at_tail,
  input  wire [IDW-1:0]                     new_id,
  input  wire signed [crrq_pkg::VOL_W-1:0]  new_vol,
  input  wire [IDW-1:0]                     upper_id,
  input  wire signed [crrq_pkg::VOL_W-1:0]  upper_vol,
  output logic [IDW-1:0]                    id,
  output logic signed [crrq_pkg::VOL_W-1:0] vol,
  output logic                              hit
);

  assign hit = valid && (id == new_id);

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      id  <= upper_id;
      vol <= upper_vol;
    end else if (ctrl.enq) begin
      if (hit) begin
        if (new_vol > vol) begin
          vol <= new_vol;
        end
      end else if (!ctrl.any_hit && at_tail) begin
        id  <= new_id;
        vol <= new_vol;
      end
    end
  end

endmodule

`default_nettype wire

[design/coalescing_request_ring_queue.sv]
// Top level of the coalescing request queue: a row of crrq_cell slots kept
// in order from the head, plus the fill count and result register.
// Depends on crrq_pkg and crrq_cell.
//
// The block takes one item in every cycle: busy never rises, and the result
// of an item appears on status, served_id and level with done high in the
// cycle after start, for exactly one cycle. Every slot compares its id with
// the incoming one at once. The queue holds at most QUEUE_DEPTH-1 requests;
// a service shifts every slot one place toward the head.
`default_nettype none

module coalescing_request_ring_queue #(
  parameter int QUEUE_DEPTH = crrq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH = crrq_pkg::ID_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode,
  input  wire [crrq_pkg::ID_PORT_W-1:0]      req_id,
  input  wire signed [crrq_pkg::VOL_W-1:0]   volume,
  output logic                               done,
  output logic [crrq_pkg::STATUS_W-1:0]      status,
  output logic [crrq_pkg::ID_PORT_W-1:0]     served_id,
  output logic [crrq_pkg::LEVEL_W-1:0]       level
);

  localparam int KEPT_W = (ID_WIDTH < crrq_pkg::ID_PORT_W) ? ID_WIDTH : crrq_pkg::ID_PORT_W;
  localparam int CNT_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH - 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             done_next;
  crrq_pkg::status_t status_reg;
  crrq_pkg::status_t status_next;
  logic [crrq_pkg::ID_PORT_W-1:0] served_id_next;
  logic [crrq_pkg::LEVEL_W-1:0]   level_next;

  logic [KEPT_W-1:0]                     cell_id  [QUEUE_DEPTH];
  logic signed [crrq_pkg::VOL_W-1:0]     cell_vol [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]                cell_hit;
  crrq_pkg::cell_ctrl_t                  ctrl;
  logic                                  accept;
  logic                                  is_empty;
  logic                                  is_full;
  logic [KEPT_W-1:0]                     in_id;
  logic signed [crrq_pkg::VOL_W-1:0]     head_vol;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_FULL);
  assign in_id    = req_id[KEPT_W-1:0];
  assign head_vol = cell_vol[0];

  assign ctrl.pop     = accept && (opcode == crrq_pkg::OP_SERVICE) && !is_empty;
  assign ctrl.enq     = accept && (opcode == crrq_pkg::OP_ENQUEUE) && !is_full;
  assign ctrl.any_hit = |cell_hit;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int UP = (i == QUEUE_DEPTH - 1) ? i : i + 1;
    crrq_cell #(
      .IDW(KEPT_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .valid    (CNT_W'(i) < count),
      .at_tail  (CNT_W'(i) == count),
      .new_id   (in_id),
      .new_vol  (volume),
      .upper_id (cell_id[UP]),
      .upper_vol(cell_vol[UP]),
      .id       (cell_id[i]),
      .vol      (cell_vol[i]),
      .hit      (cell_hit[i])
    );
  end

  always_comb begin
    count_next     = count;
    status_next    = status_reg;
    served_id_next = '0;
    level_next     = '0;
    done_next      = accept;
    if (accept) begin
      if (opcode == crrq_pkg::OP_ENQUEUE) begin
        if (is_full) begin
          status_next = crrq_pkg::ST_FULL;
        end else if (ctrl.any_hit) begin
          status_next = crrq_pkg::ST_MERGED;
        end else begin
          status_next = crrq_pkg::ST_QUEUED;
          count_next  = count + 1'b1;
        end
      end else if (is_empty) begin
        status_next = crrq_pkg::ST_EMPTY;
      end else begin
        status_next    = crrq_pkg::ST_SERVED;
        count_next     = count - 1'b1;
        served_id_next = crrq_pkg::ID_PORT_W'(cell_id[0]);
        if (head_vol[crrq_pkg::VOL_W-1] || head_vol == '0) begin
          level_next = '0;
        end else if (head_vol[crrq_pkg::VOL_W-1:1] > 15'(crrq_pkg::LEVEL_MAX)) begin
          level_next = crrq_pkg::LEVEL_MAX;
        end else begin
          level_next = head_vol[crrq_pkg::LEVEL_W:1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      done       <= 1'b0;
      status_reg <= crrq_pkg::ST_MERGED;
    end else begin
      count      <= count_next;
      done       <= done_next;
      status_reg <= status_next;
    end
    served_id <= served_id_next;
    level     <= level_next;
  end

  assign status = status_reg;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue fill count beyond capacity");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("no result in the cycle after an accepted item");

  a_served_pops: assert property (@(posedge clk) disable iff (rst)
    (done && status_reg == crrq_pkg::ST_SERVED) |-> (count == $past(count) - 1'b1))
    else $error("served result without a pop");

  a_queued_pushes: assert property (@(posedge clk) disable iff (rst)
    (done && status_reg == crrq_pkg::ST_QUEUED) |-> (count == $past(count) + 1'b1))
    else $error("queued result without a push");

endmodule

`default_nettype wire

[tb/tb_coalescing_request_ring_queue.sv]
// Testbench for the coalescing request ring queue: directed and random
// enqueue and service items, checked by a cycle-free predictor of the queue.
// Depends on crrq_pkg and the coalescing_request_ring_queue RTL.
`timescale 1ns / 100ps

module tb_coalescing_request_ring_queue;

  localparam int DEPTH = crrq_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 450;

  typedef struct packed {
    crrq_pkg::status_t st;
    logic [crrq_pkg::ID_PORT_W-1:0] id;
    logic [crrq_pkg::LEVEL_W-1:0] lvl;
  } queue_outcome_t;

  class ring_queue_scoreboard;
    logic [crrq_pkg::ID_PORT_W-1:0] slot_id [DEPTH];
    logic signed [crrq_pkg::VOL_W-1:0] slot_vol [DEPTH];
    int head;
    int tail;
    int errors;
    queue_outcome_t awaited[$];

    function new();
      head = 0;
      tail = 0;
      errors = 0;
    endfunction

    function void note_request(crrq_pkg::opcode_t op, logic [crrq_pkg::ID_PORT_W-1:0] id,
                               logic signed [crrq_pkg::VOL_W-1:0] vol);
      queue_outcome_t res;
      int half;
      res = '0;
      if (op == crrq_pkg::OP_ENQUEUE) begin
        if ((tail + 1) % DEPTH == head) begin
          res.st = crrq_pkg::ST_FULL;
        end else begin
          res.st = crrq_pkg::ST_QUEUED;
          for (int i = head; i != tail; i = (i + 1) % DEPTH) begin
            if (slot_id[i] == id) begin
              if (vol > slot_vol[i]) slot_vol[i] = vol;
              res.st = crrq_pkg::ST_MERGED;
              break;
            end
          end
          if (res.st == crrq_pkg::ST_QUEUED) begin
            slot_id[tail] = id;
            slot_vol[tail] = vol;
            tail = (tail + 1) % DEPTH;
          end
        end
      end else if (head == tail) begin
        res.st = crrq_pkg::ST_EMPTY;
      end else begin
        res.st = crrq_pkg::ST_SERVED;
        res.id = slot_id[head];
        half = slot_vol[head];
        if (half <= 0) half = 0;
        else half = half / 2;
        if (half > crrq_pkg::LEVEL_MAX) half = crrq_pkg::LEVEL_MAX;
        res.lvl = half[crrq_pkg::LEVEL_W-1:0];
        head = (head + 1) % DEPTH;
      end
      awaited.push_back(res);
    endfunction

    function void check_outcome(logic [crrq_pkg::STATUS_W-1:0] st,
                                logic [crrq_pkg::ID_PORT_W-1:0] id,
                                logic [crrq_pkg::LEVEL_W-1:0] lvl);
      queue_outcome_t exp_res;
      if (awaited.size() == 0) begin
        $error("result with no item outstanding: status %0d", st);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (st !== exp_res.st) begin
        $error("status: expected %0d, actual %0d", exp_res.st, st);
        errors++;
      end
      if (id !== exp_res.id) begin
        $error("served_id: expected %0h, actual %0h", exp_res.id, id);
        errors++;
      end
      if (lvl !== exp_res.lvl) begin
        $error("level: expected %0d, actual %0d", exp_res.lvl, lvl);
        errors++;
      end
    endfunction

    function int backlog();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic opcode = crrq_pkg::OP_ENQUEUE;
  logic [crrq_pkg::ID_PORT_W-1:0] req_id = '0;
  logic signed [crrq_pkg::VOL_W-1:0] volume = '0;
  logic busy;
  logic done;
  logic [crrq_pkg::STATUS_W-1:0] status;
  logic [crrq_pkg::ID_PORT_W-1:0] served_id;
  logic [crrq_pkg::LEVEL_W-1:0] level;

  int idle_pct = 0;
  int cycle_count = 0;
  ring_queue_scoreboard sb;

  coalescing_request_ring_queue u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .req_id(req_id),
    .volume(volume),
    .done(done),
    .status(status),
    .served_id(served_id),
    .level(level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_outcome(status, served_id, level);
      if (start && !busy) sb.note_request(crrq_pkg::opcode_t'(opcode), req_id, volume);
    end
  end

  task automatic send_item(input crrq_pkg::opcode_t op,
                           input logic [crrq_pkg::ID_PORT_W-1:0] id,
                           input logic [crrq_pkg::VOL_W-1:0] vol);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    req_id <= id;
    volume <= vol;
    do @(posedge clk); while (busy);
  endtask

  task automatic run_directed();
    logic [crrq_pkg::VOL_W-1:0] fill_vol [13];
    fill_vol = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0100, 16'h0101,
                 16'h0102, 16'h0103, 16'h5555, 16'hAAAA, 16'h00FE, 16'h0200,
                 16'h8001};
    send_item(crrq_pkg::OP_SERVICE, 16'h0000, 16'h0000);
    send_item(crrq_pkg::OP_ENQUEUE, 16'h0000, 16'h8000);
    send_item(crrq_pkg::OP_ENQUEUE, 16'hFFFF, 16'h7FFF);
    send_item(crrq_pkg::OP_ENQUEUE, 16'h0000, 16'h00FF);
    send_item(crrq_pkg::OP_ENQUEUE, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 13; i++) send_item(crrq_pkg::OP_ENQUEUE, 16'(i + 1), fill_vol[i]);
    // The queue is full here, so even a pending id is turned away.
    send_item(crrq_pkg::OP_ENQUEUE, 16'h0000, 16'h7FFF);
    send_item(crrq_pkg::OP_ENQUEUE, 16'h1234, 16'h0100);
  endtask

  task automatic run_random(input int count);
    logic [crrq_pkg::ID_PORT_W-1:0] id_pool [8];
    int service_pct;
    int vol_pick;
    logic [crrq_pkg::ID_PORT_W-1:0] id;
    logic [crrq_pkg::VOL_W-1:0] vol;
    service_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: service_pct = 15;
          1: service_pct = 50;
          default: service_pct = 85;
        endcase
        foreach (id_pool[k]) id_pool[k] = 16'($urandom_range(0, 65535));
      end
      if ($urandom_range(0, 99) < service_pct) begin
        send_item(crrq_pkg::OP_SERVICE, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 3) != 0) id = id_pool[$urandom_range(0, 7)];
        else id = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) != 0) begin
          vol = 16'($urandom_range(0, 65535));
        end else begin
          vol_pick = int'($urandom_range(0, 600)) - 100;
          vol = vol_pick[crrq_pkg::VOL_W-1:0];
        end
        send_item(crrq_pkg::OP_ENQUEUE, id, vol);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    idle_pct = 29;
    run_random(ITEMS_PER_PHASE);
    idle_pct = 68;
    run_random(ITEMS_PER_PHASE);
    idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    start <= 1'b0;
    while (sb.backlog() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.backlog() != 0) begin
      $error("%0d results never arrived", sb.backlog());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
